[rtl/core/assert_macros.svh]
// Assertion macros for the RTL of the text cell parser.
// Depends on nothing; each user provides clk and rst in its scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/atcp_pkg.sv]
// Types and constants of the text cell parser: request and cell payloads,
// parser mode and field phase codes, character codes. Depends on nothing.
package atcp_pkg;

  // Input request: one text byte
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_t;

  // Output request: one character cell
  typedef struct packed {
    logic [7:0]  char_code;
    logic        has_color;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] row;
    logic [11:0] column;
  } cell_t;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_SEQ    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  // Character codes
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_M        = 8'h6D;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;

  // Parameter values and limits
  localparam logic signed [12:0] PARAM_FG  = 13'sd38;
  localparam logic signed [12:0] PARAM_RGB = 13'sd2;
  localparam logic signed [12:0] COMP_MAX  = 13'sd255;
  localparam logic [11:0]        MAG_MAX   = 12'd4095;
  localparam int                 COORD_MAX = 4095;
  localparam logic [23:0]        COLOR_WHITE = 24'hFFFFFF;
  localparam logic [2:0]         PARAM_SLOTS = 3'd4;

endpackage

[rtl/core/ansi_truecolor_text_cell_parser.sv]
// A cell is output the cycle after its byte is taken if no older cell is queued.
// Throughput: one text byte per cycle while cell_ready is high and each byte
// yields at most one cell; two cells from one byte drop text_ready (3-entry queue).
// Reset (rst, synchronous, active high): parser state back to normal text,
// color off (white), row and column 0, queue empty, color_enable set to 1.
// Depends on atcp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ansi_truecolor_text_cell_parser #(
  parameter int MAX_ROWS    = 4096,
  parameter int MAX_COLUMNS = 4096
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_color_enable,
  input  logic           text_valid,
  output logic           text_ready,
  input  atcp_pkg::text_t text,
  output logic           cell_valid,
  input  logic           cell_ready,
  output atcp_pkg::cell_t glyph
);

  localparam int ROW_LIM_INT =
    (MAX_ROWS - 1 > atcp_pkg::COORD_MAX) ? atcp_pkg::COORD_MAX : MAX_ROWS - 1;
  localparam int COL_LIM_INT =
    (MAX_COLUMNS - 1 > atcp_pkg::COORD_MAX) ? atcp_pkg::COORD_MAX : MAX_COLUMNS - 1;
  localparam logic [11:0] ROW_LIMIT = 12'(ROW_LIM_INT);
  localparam logic [11:0] COL_LIMIT = 12'(COL_LIM_INT);

  // Parser state
  logic                   color_enable;
  atcp_pkg::mode_t        mode, mode_step, mode_next;
  atcp_pkg::phase_t       phase, phase_next;
  logic                   started, started_next;
  logic                   negative, negative_next;
  logic [11:0]            magnitude, magnitude_next;
  logic signed [12:0]     params [4];
  logic signed [12:0]     params_next [4];
  logic [2:0]             pcount, pcount_next;
  logic                   triple_found, triple_found_next;
  logic [23:0]            found_color, found_color_next;
  logic                   zero_seen, zero_seen_next;
  logic                   color_active, color_active_next;
  logic [23:0]            current_color, current_color_next;
  logic [11:0]            line_index, line_index_next;
  logic [11:0]            column_index, column_index_next;

  // Cells made by the current byte
  atcp_pkg::cell_t        res0, res1;
  logic [1:0]             nres;

  // Cell queue, entry 0 is the output register
  atcp_pkg::cell_t        queue [3];
  atcp_pkg::cell_t        queue_next [3];
  logic [1:0]             count, count_next;

  logic                   accept, pop;
  logic [7:0]             b;
  logic                   is_digit, is_space, is_sign;
  logic [16:0]            mag_calc;
  logic signed [12:0]     pval;

  function automatic logic [7:0] clamp8(input logic signed [12:0] v);
    if (v < 0) return 8'd0;
    if (v > atcp_pkg::COMP_MAX) return 8'hFF;
    return v[7:0];
  endfunction

  function automatic logic [11:0] sat_inc(input logic [11:0] x, input logic [11:0] lim);
    return (x < lim) ? x + 12'd1 : x;
  endfunction

  function automatic atcp_pkg::cell_t make_cell(
    input logic [7:0]  ch,
    input logic        active,
    input logic [23:0] color,
    input logic [11:0] ln,
    input logic [11:0] col
  );
    atcp_pkg::cell_t c;
    c.char_code = ch;
    c.has_color = active;
    c.red       = active ? color[23:16] : 8'd0;
    c.green     = active ? color[15:8]  : 8'd0;
    c.blue      = active ? color[7:0]   : 8'd0;
    c.row       = ln;
    c.column    = col;
    return c;
  endfunction

  // Handshakes
  assign cfg_ready  = 1'b1;
  assign text_ready = (count <= 2'd1);
  assign accept     = text_valid && text_ready;
  assign pop        = cell_valid && cell_ready;

  // Byte classes
  assign b        = text.text_byte;
  assign is_digit = (b >= atcp_pkg::CH_ZERO) && (b <= atcp_pkg::CH_NINE);
  assign is_space = (b == atcp_pkg::CH_SPACE) ||
                    ((b >= atcp_pkg::CH_TAB) && (b <= atcp_pkg::CH_CR));
  assign is_sign  = (b == atcp_pkg::CH_PLUS) || (b == atcp_pkg::CH_MINUS);
  assign mag_calc = ({5'd0, magnitude} << 3) + ({5'd0, magnitude} << 1) +
                    {13'd0, b[3:0]};
  assign pval     = negative ? -$signed({1'b0, magnitude}) : $signed({1'b0, magnitude});

  // Next parser mode
  always_comb begin
    case (mode)
      atcp_pkg::MODE_ESC: begin
        if (b == atcp_pkg::CH_LBRACKET) begin
          mode_step = atcp_pkg::MODE_SEQ;
        end else if (b == atcp_pkg::CH_ESC && color_enable) begin
          mode_step = atcp_pkg::MODE_ESC;
        end else begin
          mode_step = atcp_pkg::MODE_NORMAL;
        end
      end
      atcp_pkg::MODE_SEQ: begin
        mode_step = (b == atcp_pkg::CH_M) ? atcp_pkg::MODE_NORMAL : atcp_pkg::MODE_SEQ;
      end
      default: begin
        mode_step = (b == atcp_pkg::CH_ESC && color_enable) ?
                    atcp_pkg::MODE_ESC : atcp_pkg::MODE_NORMAL;
      end
    endcase
    mode_next = text.end_of_text ? atcp_pkg::MODE_NORMAL : mode_step;
  end

  // Field parsing, color, position and cell generation
  always_comb begin
    logic in_seq, seq_end, seq_semi, do_normal, consumed, seq_clear;
    in_seq    = (mode == atcp_pkg::MODE_SEQ);
    seq_end   = in_seq && (b == atcp_pkg::CH_M);
    seq_semi  = in_seq && (b == atcp_pkg::CH_SEMI);
    do_normal = (mode == atcp_pkg::MODE_ESC) ? (b != atcp_pkg::CH_LBRACKET) : !in_seq;
    consumed  = 1'b0;
    seq_clear = 1'b0;

    phase_next         = phase;
    started_next       = started;
    negative_next      = negative;
    magnitude_next     = magnitude;
    params_next        = params;
    pcount_next        = pcount;
    triple_found_next  = triple_found;
    found_color_next   = found_color;
    zero_seen_next     = zero_seen;
    color_active_next  = color_active;
    current_color_next = current_color;
    line_index_next    = line_index;
    column_index_next  = column_index;
    res0 = '0;
    res1 = '0;
    nres = 2'd0;

    // Pending ESC not followed by '[' becomes a cell; '[' opens a sequence
    if (mode == atcp_pkg::MODE_ESC) begin
      if (b == atcp_pkg::CH_LBRACKET) begin
        seq_clear = 1'b1;
      end else begin
        res0 = make_cell(atcp_pkg::CH_ESC, color_active, current_color,
                         line_index, column_index);
        column_index_next = sat_inc(column_index, COL_LIMIT);
        nres = 2'd1;
      end
    end

    // Normal text byte
    if (do_normal) begin
      if (b == atcp_pkg::CH_LF) begin
        line_index_next   = sat_inc(line_index, ROW_LIMIT);
        column_index_next = '0;
      end else if (b == atcp_pkg::CH_CR) begin
        consumed = 1'b0;
      end else if (!(b == atcp_pkg::CH_ESC && color_enable)) begin
        if (nres == 2'd0) begin
          res0 = make_cell(b, color_active, current_color,
                           line_index_next, column_index_next);
        end else begin
          res1 = make_cell(b, color_active, current_color,
                           line_index_next, column_index_next);
        end
        column_index_next = sat_inc(column_index_next, COL_LIMIT);
        nres = nres + 2'd1;
      end
    end

    // Close the current field and push its value
    if ((seq_end || seq_semi) && started) begin
      if (pval == 13'sd0) zero_seen_next = 1'b1;
      if (pcount >= atcp_pkg::PARAM_SLOTS && !triple_found &&
          params[0] == atcp_pkg::PARAM_FG && params[1] == atcp_pkg::PARAM_RGB) begin
        found_color_next  = {clamp8(params[2]), clamp8(params[3]), clamp8(pval)};
        triple_found_next = 1'b1;
      end
      params_next[0] = params[1];
      params_next[1] = params[2];
      params_next[2] = params[3];
      params_next[3] = pval;
      if (pcount < atcp_pkg::PARAM_SLOTS) pcount_next = pcount + 3'd1;
    end
    if (seq_end || seq_semi) begin
      phase_next     = atcp_pkg::PH_SKIP;
      started_next   = 1'b0;
      negative_next  = 1'b0;
      magnitude_next = '0;
    end

    // Apply the sequence at its final 'm'
    if (seq_end) begin
      if (pcount_next == 3'd0) begin
        color_active_next  = 1'b0;
        current_color_next = atcp_pkg::COLOR_WHITE;
      end else begin
        if (triple_found_next) begin
          current_color_next = found_color_next;
          color_active_next  = 1'b1;
        end
        if (zero_seen_next) begin
          color_active_next  = 1'b0;
          current_color_next = atcp_pkg::COLOR_WHITE;
        end
      end
      seq_clear = 1'b1;
    end

    // Accumulate a field byte
    if (in_seq && !seq_end && !seq_semi) begin
      started_next = 1'b1;
      if (phase == atcp_pkg::PH_SKIP) begin
        if (is_space) begin
          consumed = 1'b1;
        end else if (is_sign) begin
          negative_next = (b == atcp_pkg::CH_MINUS);
          phase_next    = atcp_pkg::PH_DIGITS;
          consumed      = 1'b1;
        end else begin
          phase_next = is_digit ? atcp_pkg::PH_DIGITS : atcp_pkg::PH_DONE;
        end
      end
      if (!consumed && phase_next == atcp_pkg::PH_DIGITS) begin
        if (is_digit) begin
          magnitude_next = (mag_calc > {5'd0, atcp_pkg::MAG_MAX}) ?
                           atcp_pkg::MAG_MAX : mag_calc[11:0];
        end else begin
          phase_next = atcp_pkg::PH_DONE;
        end
      end
    end

    if (seq_clear) begin
      phase_next        = atcp_pkg::PH_SKIP;
      started_next      = 1'b0;
      negative_next     = 1'b0;
      magnitude_next    = '0;
      params_next       = '{default: '0};
      pcount_next       = '0;
      triple_found_next = 1'b0;
      found_color_next  = '0;
      zero_seen_next    = 1'b0;
    end

    // End of text: flush a pending ESC, then drop all state
    if (text.end_of_text) begin
      if (mode_step == atcp_pkg::MODE_ESC) begin
        if (nres == 2'd0) begin
          res0 = make_cell(atcp_pkg::CH_ESC, color_active, current_color,
                           line_index_next, column_index_next);
        end else begin
          res1 = make_cell(atcp_pkg::CH_ESC, color_active, current_color,
                           line_index_next, column_index_next);
        end
        nres = nres + 2'd1;
      end
      phase_next         = atcp_pkg::PH_SKIP;
      started_next       = 1'b0;
      negative_next      = 1'b0;
      magnitude_next     = '0;
      params_next        = '{default: '0};
      pcount_next        = '0;
      triple_found_next  = 1'b0;
      found_color_next   = '0;
      zero_seen_next     = 1'b0;
      color_active_next  = 1'b0;
      current_color_next = atcp_pkg::COLOR_WHITE;
      line_index_next    = '0;
      column_index_next  = '0;
    end
  end

  // Queue: shift out on pop, append new cells behind the remaining ones
  always_comb begin
    logic [1:0] base;
    logic [1:0] nadd;
    base = count - {1'b0, pop};
    nadd = accept ? nres : 2'd0;
    queue_next = queue;
    if (pop) begin
      queue_next[0] = queue[1];
      queue_next[1] = queue[2];
    end
    for (int i = 0; i < 3; i++) begin
      if (nadd != 2'd0 && base == 2'(i)) queue_next[i] = res0;
      if (nadd == 2'd2 && base + 2'd1 == 2'(i)) queue_next[i] = res1;
    end
    count_next = base + nadd;
  end

  // Outputs
  always_comb begin
    cell_valid = (count != 2'd0);
    glyph      = queue[0];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      color_enable  <= 1'b1;
      mode          <= atcp_pkg::MODE_NORMAL;
      phase         <= atcp_pkg::PH_SKIP;
      started       <= 1'b0;
      negative      <= 1'b0;
      magnitude     <= '0;
      params        <= '{default: '0};
      pcount        <= '0;
      triple_found  <= 1'b0;
      found_color   <= '0;
      zero_seen     <= 1'b0;
      color_active  <= 1'b0;
      current_color <= atcp_pkg::COLOR_WHITE;
      line_index    <= '0;
      column_index  <= '0;
      count         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) color_enable <= cfg_color_enable;
      if (accept) begin
        mode          <= mode_next;
        phase         <= phase_next;
        started       <= started_next;
        negative      <= negative_next;
        magnitude     <= magnitude_next;
        params        <= params_next;
        pcount        <= pcount_next;
        triple_found  <= triple_found_next;
        found_color   <= found_color_next;
        zero_seen     <= zero_seen_next;
        color_active  <= color_active_next;
        current_color <= current_color_next;
        line_index    <= line_index_next;
        column_index  <= column_index_next;
      end
      count <= count_next;
    end
  end

  // Queue payload
  always_ff @(posedge clk) begin
    queue <= queue_next;
  end

  `ASSERT_CLK(a_eot_clears, (text_valid && text_ready && text.end_of_text) |=> (mode == atcp_pkg::MODE_NORMAL && line_index == 12'd0 && column_index == 12'd0), "end of text did not reset parser")
  `ASSERT_CLK(a_no_growth, !(text_valid && text_ready) |=> (count <= $past(count)), "queue grew without a request")
  `ASSERT_CLK(a_pcount_max, pcount <= atcp_pkg::PARAM_SLOTS, "parameter count out of range")
  `ASSERT_CLK(a_triple_full, !triple_found || pcount == atcp_pkg::PARAM_SLOTS, "color found with fewer than four parameters")
  `ASSERT_CLK(a_no_color_zero, (cell_valid && !glyph.has_color) |-> (glyph.red == 8'd0 && glyph.green == 8'd0 && glyph.blue == 8'd0), "uncolored cell carries color")

endmodule

[verif/cell_stream_checker.sv]
// Cell stream checker for the text cell parser: watches the config, text and cell
// channels, tracks parser state on its own and compares every cell taken.
// Depends on atcp_pkg for the payload types, parser codes and character codes.
module cell_stream_checker #(
  parameter int MAX_ROWS    = 4096,
  parameter int MAX_COLUMNS = 4096
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic            cfg_color_enable,
  input  logic            text_valid,
  input  logic            text_ready,
  input  atcp_pkg::text_t text_req,
  input  logic            cell_valid,
  input  logic            cell_ready,
  input  atcp_pkg::cell_t cell_data,
  output int              mismatches,
  output int              pending,
  output int              cells_checked,
  output int              colored_cells
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_LAST =
    (MAX_ROWS - 1 > atcp_pkg::COORD_MAX) ? atcp_pkg::COORD_MAX : MAX_ROWS - 1;
  localparam int COL_LAST =
    (MAX_COLUMNS - 1 > atcp_pkg::COORD_MAX) ? atcp_pkg::COORD_MAX : MAX_COLUMNS - 1;
  localparam int PRINT_CAP = 100;

  // Tracked parser state
  logic               esc_enabled;
  atcp_pkg::mode_t    parse_state;
  atcp_pkg::phase_t   field_state;
  logic               field_open;
  logic               field_neg;
  logic [11:0]        field_mag;
  logic signed [12:0] param_hist [4];
  logic [2:0]         param_total;
  logic               rgb_captured;
  logic [23:0]        captured_rgb;
  logic               saw_zero;
  logic               color_on;
  logic [23:0]        active_rgb;
  logic [11:0]        row_now;
  logic [11:0]        col_now;

  // Cells predicted but not yet seen, oldest first
  atcp_pkg::cell_t cells_due[$];

  function void clear_field();
    field_state = atcp_pkg::PH_SKIP;
    field_open = 1'b0;
    field_neg = 1'b0;
    field_mag = '0;
  endfunction

  function void clear_sequence();
    clear_field();
    for (int i = 0; i < 4; i++) param_hist[i] = '0;
    param_total = '0;
    rgb_captured = 1'b0;
    captured_rgb = '0;
    saw_zero = 1'b0;
  endfunction

  function void clear_text();
    parse_state = atcp_pkg::MODE_NORMAL;
    clear_sequence();
    color_on = 1'b0;
    active_rgb = atcp_pkg::COLOR_WHITE;
    row_now = '0;
    col_now = '0;
  endfunction

  function logic [7:0] clamp_component(input logic signed [12:0] v);
    if (v < 0) return 8'd0;
    if (v > atcp_pkg::COMP_MAX) return 8'hFF;
    return v[7:0];
  endfunction

  // Queue one cell at the current position and step the column
  function void emit_cell(input logic [7:0] ch);
    atcp_pkg::cell_t c;
    c.char_code = ch;
    c.has_color = color_on;
    c.red       = color_on ? active_rgb[23:16] : 8'd0;
    c.green     = color_on ? active_rgb[15:8] : 8'd0;
    c.blue      = color_on ? active_rgb[7:0] : 8'd0;
    c.row       = row_now;
    c.column    = col_now;
    cells_due.insert(cells_due.size(), c);
    if (col_now < COL_LAST) col_now++;
  endfunction

  // Shift a parameter in; capture the first 38;2;R;G;B run
  function void push_param(input logic signed [12:0] v);
    if (v == 0) saw_zero = 1'b1;
    if (param_total >= atcp_pkg::PARAM_SLOTS && !rgb_captured &&
        param_hist[0] == atcp_pkg::PARAM_FG && param_hist[1] == atcp_pkg::PARAM_RGB) begin
      captured_rgb = {clamp_component(param_hist[2]), clamp_component(param_hist[3]),
                      clamp_component(v)};
      rgb_captured = 1'b1;
    end
    param_hist[0] = param_hist[1];
    param_hist[1] = param_hist[2];
    param_hist[2] = param_hist[3];
    param_hist[3] = v;
    if (param_total < atcp_pkg::PARAM_SLOTS) param_total++;
  endfunction

  function void finish_field();
    logic signed [12:0] m;
    if (field_open) begin
      m = {1'b0, field_mag};
      if (field_neg) m = -m;
      push_param(m);
    end
    clear_field();
  endfunction

  // Accumulate one byte of a field, atoi style, saturating the magnitude
  function void feed_field(input logic [7:0] b);
    logic is_digit;
    int   acc;
    is_digit = (b >= atcp_pkg::CH_ZERO && b <= atcp_pkg::CH_NINE);
    field_open = 1'b1;
    if (field_state == atcp_pkg::PH_SKIP) begin
      if (b == atcp_pkg::CH_SPACE || (b >= atcp_pkg::CH_TAB && b <= atcp_pkg::CH_CR)) return;
      if (b == atcp_pkg::CH_PLUS || b == atcp_pkg::CH_MINUS) begin
        field_neg = (b == atcp_pkg::CH_MINUS);
        field_state = atcp_pkg::PH_DIGITS;
        return;
      end
      if (is_digit) field_state = atcp_pkg::PH_DIGITS;
      else field_state = atcp_pkg::PH_DONE;
    end
    if (field_state == atcp_pkg::PH_DIGITS) begin
      if (is_digit) begin
        acc = field_mag * 10 + (b - atcp_pkg::CH_ZERO);
        field_mag = (acc > atcp_pkg::MAG_MAX) ? atcp_pkg::MAG_MAX : acc[11:0];
      end else begin
        field_state = atcp_pkg::PH_DONE;
      end
    end
  endfunction

  function void sequence_byte(input logic [7:0] b);
    if (b == atcp_pkg::CH_M) begin
      finish_field();
      if (param_total == 0) begin
        color_on = 1'b0;
        active_rgb = atcp_pkg::COLOR_WHITE;
      end else begin
        if (rgb_captured) begin
          active_rgb = captured_rgb;
          color_on = 1'b1;
        end
        if (saw_zero) begin
          color_on = 1'b0;
          active_rgb = atcp_pkg::COLOR_WHITE;
        end
      end
      clear_sequence();
      parse_state = atcp_pkg::MODE_NORMAL;
    end else if (b == atcp_pkg::CH_SEMI) begin
      finish_field();
    end else begin
      feed_field(b);
    end
  endfunction

  function void normal_byte(input logic [7:0] b);
    if (b == atcp_pkg::CH_LF) begin
      if (row_now < ROW_LAST) row_now++;
      col_now = '0;
    end else if (b == atcp_pkg::CH_CR) begin
      // dropped
    end else if (b == atcp_pkg::CH_ESC && esc_enabled) begin
      parse_state = atcp_pkg::MODE_ESC;
    end else begin
      emit_cell(b);
    end
  endfunction

  // Advance the tracked parser by one text byte, queueing the cells it yields
  function void parse_text_byte(input atcp_pkg::text_t t);
    case (parse_state)
      atcp_pkg::MODE_ESC: begin
        if (t.text_byte == atcp_pkg::CH_LBRACKET) begin
          clear_sequence();
          parse_state = atcp_pkg::MODE_SEQ;
        end else begin
          emit_cell(atcp_pkg::CH_ESC);
          parse_state = atcp_pkg::MODE_NORMAL;
          normal_byte(t.text_byte);
        end
      end
      atcp_pkg::MODE_SEQ: sequence_byte(t.text_byte);
      default: begin
        parse_state = atcp_pkg::MODE_NORMAL;
        normal_byte(t.text_byte);
      end
    endcase
    if (t.end_of_text) begin
      if (parse_state == atcp_pkg::MODE_ESC) emit_cell(atcp_pkg::CH_ESC);
      clear_text();
    end
  endfunction

  // Count a mismatch; go quiet after the first screenful
  task report(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task field_check(input string name, input int got, input int want);
    if (got != want) begin
      report($sformatf("cell %0d %s: got 0x%0h, want 0x%0h", cells_checked, name, got, want));
    end
  endtask

  task check_cell(input atcp_pkg::cell_t got);
    atcp_pkg::cell_t want;
    if (cells_due.size() == 0) begin
      report($sformatf("cell with char 0x%0h arrived with nothing expected", got.char_code));
      return;
    end
    want = cells_due.pop_front();
    field_check("char_code", got.char_code, want.char_code);
    field_check("has_color", got.has_color, want.has_color);
    field_check("red", got.red, want.red);
    field_check("green", got.green, want.green);
    field_check("blue", got.blue, want.blue);
    field_check("row", got.row, want.row);
    field_check("column", got.column, want.column);
    if (want.has_color) colored_cells++;
    cells_checked++;
  endtask

  // Sample all three channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      esc_enabled = 1'b1;
      clear_text();
      cells_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) esc_enabled = cfg_color_enable;
      if (cell_valid && cell_ready) check_cell(cell_data);
      if (text_valid && text_ready) parse_text_byte(text_req);
    end
    pending = cells_due.size();
  end

endmodule

[verif/ansi_truecolor_text_cell_parser_test.sv]
// Top of the text cell parser test: clock, reset, text and config stimulus,
// cell receiver with stalls, verdict. Depends on atcp_pkg, the parser RTL and
// cell_stream_checker, which predicts and compares the cells.
module ansi_truecolor_text_cell_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int LONG_RUN     = 20;

  typedef enum {STALL_NONE, STALL_COIN, STALL_EVERY4, STALL_RARE} stall_t;

  logic  clk = 1'b0;
  logic  rst;
  logic  cfg_valid;
  logic  cfg_ready;
  logic  cfg_color_enable;
  logic  text_valid;
  logic  text_ready;
  atcp_pkg::text_t text_req;
  logic  cell_valid;
  logic  cell_ready;
  atcp_pkg::cell_t cell_out;

  int mismatches;
  int pending;
  int cells_checked;
  int colored_cells;

  int cycles;
  int items_sent;
  int burst_left;
  int hold_requests;
  int holds_done;
  int hold_left;
  int style_age;
  stall_t stall_style;

  logic [7:0] chunk[$];

  always #5 clk = ~clk;

  // Ports in declaration order: clk, rst, config, text, cell
  ansi_truecolor_text_cell_parser #(
    .MAX_ROWS(4096),
    .MAX_COLUMNS(4096)
  ) dut (
    clk, rst,
    cfg_valid, cfg_ready, cfg_color_enable,
    text_valid, text_ready, text_req,
    cell_valid, cell_ready, cell_out
  );

  cell_stream_checker #(
    .MAX_ROWS(4096),
    .MAX_COLUMNS(4096)
  ) scoreboard (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_color_enable(cfg_color_enable),
    .text_valid(text_valid),
    .text_ready(text_ready),
    .text_req(text_req),
    .cell_valid(cell_valid),
    .cell_ready(cell_ready),
    .cell_data(cell_out),
    .mismatches(mismatches),
    .pending(pending),
    .cells_checked(cells_checked),
    .colored_cells(colored_cells)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Cell receiver: hold off on request, otherwise stall on a changing pattern
  always @(negedge clk) begin
    if (hold_left > 0) begin
      cell_ready <= 1'b0;
      hold_left--;
    end else if (holds_done < hold_requests) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      cell_ready <= 1'b0;
    end else begin
      if (style_age == 0) begin
        stall_style = stall_t'($urandom_range(0, 3));
        style_age = $urandom_range(50, 400);
      end
      style_age--;
      case (stall_style)
        STALL_NONE:   cell_ready <= 1'b1;
        STALL_COIN:   cell_ready <= ($urandom_range(0, 1) == 1);
        STALL_EVERY4: cell_ready <= (cycles % 4 == 0);
        default:      cell_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Offer one text request; bursts of random length with random gaps between
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 48);
      if (gap > 0) begin
        text_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    text_valid <= 1'b1;
    text_req <= '{text_byte: b, end_of_text: eot};
    do @(posedge clk); while (!text_ready);
    burst_left--;
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_chunk(input int eot_at);
    for (int i = 0; i < chunk.size(); i++) send_byte(chunk[i], i == eot_at);
    chunk.delete();
  endtask

  // Drop valid and wait until every predicted cell has come out
  task automatic settle();
    text_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_color_enable(input logic en);
    cfg_valid <= 1'b1;
    cfg_color_enable <= en;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Append one byte to the chunk being built
  function automatic void add_byte(input logic [7:0] b);
    chunk.insert(chunk.size(), b);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_number(input int v);
    add_text($sformatf("%0d", v));
  endfunction

  // One parameter field of arbitrary shape
  function automatic void add_field();
    int pick;
    pick = $urandom_range(0, 15);
    case (pick)
      0: ;
      1: add_number(0);
      2: add_number($urandom_range(0, 255));
      3: add_number($urandom_range(256, 4095));
      4: add_number($urandom_range(4096, 999999));
      5: begin
        add_byte(atcp_pkg::CH_MINUS);
        add_number($urandom_range(1, 4200));
      end
      6: begin
        add_byte(atcp_pkg::CH_PLUS);
        add_number($urandom_range(0, 300));
      end
      7: begin
        add_byte(atcp_pkg::CH_SPACE);
        add_byte(atcp_pkg::CH_TAB);
        add_number($urandom_range(0, 99));
      end
      8: add_byte(8'($urandom_range(8'h61, 8'h6C)));
      9: add_text("12 7");
      10: add_byte(atcp_pkg::CH_MINUS);
      11: add_text("  ");
      12: add_number(38);
      13: add_number(2);
      default: add_number($urandom_range(1, 255));
    endcase
  endfunction

  // One color component: mostly in range, sometimes to be clamped
  function automatic void add_component();
    int pick;
    pick = $urandom_range(0, 19);
    case (pick)
      0: add_number($urandom_range(256, 4095));
      1: add_number($urandom_range(4096, 99999));
      2: begin
        add_byte(atcp_pkg::CH_MINUS);
        add_number($urandom_range(1, 300));
      end
      3: begin
        add_byte(atcp_pkg::CH_SPACE);
        add_number($urandom_range(0, 255));
      end
      4: begin
        add_byte(atcp_pkg::CH_PLUS);
        add_number($urandom_range(0, 255));
      end
      5: add_number(0);
      6: add_number(255);
      default: add_number($urandom_range(1, 255));
    endcase
  endfunction

  // Well-formed escape sequence with random content
  function automatic void make_sequence();
    int style;
    int fields;
    add_byte(atcp_pkg::CH_ESC);
    add_byte(atcp_pkg::CH_LBRACKET);
    style = $urandom_range(0, 9);
    if (style == 1) begin
      add_number(0);
    end else if (style >= 2 && style <= 6) begin
      fields = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      repeat (fields) begin
        add_field();
        add_byte(atcp_pkg::CH_SEMI);
      end
      add_number(38);
      add_byte(atcp_pkg::CH_SEMI);
      add_number(2);
      repeat (3) begin
        add_byte(atcp_pkg::CH_SEMI);
        add_component();
      end
      repeat ($urandom_range(0, 2)) begin
        add_byte(atcp_pkg::CH_SEMI);
        add_field();
      end
    end else if (style >= 7) begin
      fields = $urandom_range(1, 5);
      for (int i = 0; i < fields; i++) begin
        if (i > 0) add_byte(atcp_pkg::CH_SEMI);
        add_field();
      end
    end
    add_byte(atcp_pkg::CH_M);
  endfunction

  // Plain text with line breaks and the odd arbitrary byte
  function automatic void make_plain();
    int pick;
    repeat ($urandom_range(1, 12)) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) add_byte(atcp_pkg::CH_LF);
      else if (pick == 1) add_byte(atcp_pkg::CH_CR);
      else if (pick <= 3) add_byte(8'($urandom_range(0, 255)));
      else add_byte(8'($urandom_range(8'h20, 8'h7E)));
    end
  endfunction

  // Broken sequences; returns 1 when the chunk must end the text
  function automatic bit make_noise();
    logic [7:0] b;
    int pick;
    pick = $urandom_range(0, 3);
    add_byte(atcp_pkg::CH_ESC);
    case (pick)
      0: begin
        b = 8'($urandom_range(0, 255));
        if (b == atcp_pkg::CH_LBRACKET) b = "q";
        add_byte(b);
      end
      1: begin
        add_byte(atcp_pkg::CH_LBRACKET);
        add_field();
        case ($urandom_range(0, 3))
          0: add_byte(atcp_pkg::CH_LF);
          1: add_byte(atcp_pkg::CH_CR);
          2: add_byte(atcp_pkg::CH_ESC);
          default: add_byte(8'($urandom_range(128, 255)));
        endcase
        add_field();
        add_byte(atcp_pkg::CH_M);
      end
      2: begin
        add_byte(atcp_pkg::CH_LBRACKET);
        repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
      end
      default: return 1'b1;
    endcase
    return 1'b0;
  endfunction

  // Build one chunk; returns the index carrying end of text, or -1
  function automatic int make_chunk();
    int pick;
    bit must_end;
    must_end = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 55) make_sequence();
    else if (pick < 85) make_plain();
    else must_end = make_noise();
    pick = $urandom_range(0, 29);
    if (must_end || pick <= 1) return chunk.size() - 1;
    if (pick == 2) return $urandom_range(0, chunk.size() - 1);
    return -1;
  endfunction

  task automatic run_random(input int count);
    int target;
    int eot_at;
    target = items_sent + count;
    while (items_sent < target) begin
      eot_at = make_chunk();
      send_chunk(eot_at);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_color_enable = 1'b0;
    text_valid = 1'b0;
    text_req = '0;
    cell_ready = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed: byte extremes, line control, lone and pending ESC, empty list
    write_color_enable(1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(atcp_pkg::CH_CR, 1'b0);
    send_byte(atcp_pkg::CH_LF, 1'b0);
    send_byte("Z", 1'b0);
    send_byte(atcp_pkg::CH_ESC, 1'b0);
    send_byte("q", 1'b0);
    send_byte(atcp_pkg::CH_ESC, 1'b0);
    send_byte(atcp_pkg::CH_LBRACKET, 1'b0);
    send_byte(atcp_pkg::CH_M, 1'b0);
    send_byte(atcp_pkg::CH_ESC, 1'b1);
    send_byte(atcp_pkg::CH_ESC, 1'b0);
    send_byte(atcp_pkg::CH_LBRACKET, 1'b0);
    send_byte("7", 1'b1);
    settle();

    // ESC as ordinary text
    write_color_enable(1'b0);
    run_random(300);
    settle();

    // Sequence parsing, with a long receiver hold-off partway through
    write_color_enable(1'b1);
    run_random(200);
    hold_requests++;
    run_random(500);
    settle();

    // Flip the enable in the middle of an open sequence with a color active
    add_text("\x1b[38;2;10;20;30mab\x1b[38;2;");
    send_chunk(-1);
    settle();
    write_color_enable(1'b0);
    add_text("4;5;6mcd\x1bx");
    send_chunk(-1);
    settle();
    write_color_enable(1'b1);
    run_random(200);
    hold_requests++;
    run_random(250);
    settle();

    // One long line, then a run of blank lines, then text further down
    send_byte(atcp_pkg::CH_SPACE, 1'b1);
    repeat (LONG_RUN) send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
    repeat (LONG_RUN) send_byte(atcp_pkg::CH_LF, 1'b0);
    send_byte("a", 1'b0);
    send_byte("b", 1'b1);
    settle();

    $display("Covered %0d text bytes with ESC parsing on and off, clamped and cleared colors,",
             items_sent);
    $display("long receiver hold-offs and text resets; checked %0d cells, %0d with color.",
             cells_checked, colored_cells);
    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
